// ===== design/vtlv_pkg.sv =====
// Package: shared constants, codes and the result record for the vendor option TLV parser.
package vtlv_pkg;

    localparam int EntBytes = 4;
    localparam int HdrBytes = 4;
    localparam int CntW     = $clog2(EntBytes);

    // Parser phase codes
    localparam logic [1:0] PH_ENTERPRISE = 2'd0;
    localparam logic [1:0] PH_HEADER     = 2'd1;
    localparam logic [1:0] PH_DATA       = 2'd2;

    // Event kinds
    localparam logic [1:0] EV_HDR_BYTE   = 2'd0;
    localparam logic [1:0] EV_ENTERPRISE = 2'd1;
    localparam logic [1:0] EV_SUB_HEADER = 2'd2;
    localparam logic [1:0] EV_DATA       = 2'd3;

    // Status codes, reported on the final byte
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_SHORT     = 2'd1;
    localparam logic [1:0] ST_TRUNCATED = 2'd2;
    localparam logic [1:0] ST_TRAILING  = 2'd3;

    localparam logic [CntW-1:0] EntLast = CntW'(EntBytes - 1);
    localparam logic [CntW-1:0] HdrLast = CntW'(HdrBytes - 1);

    // Header byte positions within a sub-option header
    localparam logic [CntW-1:0] HB_CODE_HI = 2'd0;
    localparam logic [CntW-1:0] HB_CODE_LO = 2'd1;
    localparam logic [CntW-1:0] HB_LEN_HI  = 2'd2;

    typedef struct packed {
        logic [1:0]  event_kind;
        logic [31:0] enterprise_number;
        logic [15:0] sub_code;
        logic [15:0] sub_length;
        logic [7:0]  data_value;
        logic [15:0] data_offset;
        logic        sub_complete;
        logic        done_res;
        logic [1:0]  status;
    } vtlv_result_t;

endpackage

// ===== design/vtlv_if.sv =====
// Interfaces: byte request channel and parse result channel.
interface vtlv_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] payload_byte;
    logic       final_byte;

    modport source (output valid, output payload_byte, output final_byte, input ready);
    modport sink   (input valid, input payload_byte, input final_byte, output ready);
endinterface

interface vtlv_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  event_kind;
    logic [31:0] enterprise_number;
    logic [15:0] sub_code;
    logic [15:0] sub_length;
    logic [7:0]  data_value;
    logic [15:0] data_offset;
    logic        sub_complete;
    logic        done_res;
    logic [1:0]  status;

    modport source (
        output valid, output event_kind, output enterprise_number, output sub_code,
        output sub_length, output data_value, output data_offset, output sub_complete,
        output done_res, output status, input ready
    );
    modport sink (
        input valid, input event_kind, input enterprise_number, input sub_code,
        input sub_length, input data_value, input data_offset, input sub_complete,
        input done_res, input status, output ready
    );
endinterface

// ===== design/vtlv_parse_core.sv =====
// Parse state registers and the per-byte next-state / result logic.
module vtlv_parse_core (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  accept,
    input  logic [7:0]            payload_byte,
    input  logic                  final_byte,
    output vtlv_pkg::vtlv_result_t res
);

    logic [1:0]               phase_reg, phase_next;
    logic [vtlv_pkg::CntW-1:0] cnt_reg, cnt_next;
    logic [31:0]              ent_reg, ent_next;
    logic [15:0]              code_reg, code_next;
    logic [15:0]              length_reg, length_next;
    logic [15:0]              remaining_reg, remaining_next;
    logic [15:0]              offset_reg, offset_next;

    always_comb
    begin
        phase_next     = phase_reg;
        cnt_next       = cnt_reg;
        ent_next       = ent_reg;
        code_next      = code_reg;
        length_next    = length_reg;
        remaining_next = remaining_reg;
        offset_next    = offset_reg;

        res              = '0;
        res.done_res     = final_byte;

        case (phase_reg)
            vtlv_pkg::PH_HEADER:
            begin
                case (cnt_reg)
                    vtlv_pkg::HB_CODE_HI:
                    begin
                        code_next   = {payload_byte, 8'h00};
                        length_next = '0;
                    end
                    vtlv_pkg::HB_CODE_LO: code_next   = {code_reg[15:8], payload_byte};
                    vtlv_pkg::HB_LEN_HI:  length_next = {payload_byte, 8'h00};
                    default:              length_next = {length_reg[15:8], payload_byte};
                endcase
                if (cnt_reg == vtlv_pkg::HdrLast)
                begin
                    res.event_kind = vtlv_pkg::EV_SUB_HEADER;
                    cnt_next       = '0;
                    if (length_next == 16'd0)
                    begin
                        res.sub_complete = 1'b1;
                        res.status       = vtlv_pkg::ST_OK;
                    end
                    else
                    begin
                        remaining_next = length_next;
                        offset_next    = '0;
                        phase_next     = vtlv_pkg::PH_DATA;
                        res.status     = vtlv_pkg::ST_TRUNCATED;
                    end
                end
                else
                begin
                    res.event_kind = vtlv_pkg::EV_HDR_BYTE;
                    cnt_next       = cnt_reg + 1'b1;
                    res.status     = vtlv_pkg::ST_TRAILING;
                end
            end
            vtlv_pkg::PH_DATA:
            begin
                res.event_kind  = vtlv_pkg::EV_DATA;
                res.data_value  = payload_byte;
                res.data_offset = offset_reg;
                offset_next     = offset_reg + 16'd1;
                remaining_next  = remaining_reg - 16'd1;
                if (remaining_next == 16'd0)
                begin
                    res.sub_complete = 1'b1;
                    phase_next       = vtlv_pkg::PH_HEADER;
                    cnt_next         = '0;
                    res.status       = vtlv_pkg::ST_OK;
                end
                else
                begin
                    res.status = vtlv_pkg::ST_TRUNCATED;
                end
            end
            default:
            begin
                // enterprise phase, and the unused phase code
                ent_next = {ent_reg[23:0], payload_byte};
                if (cnt_reg == vtlv_pkg::EntLast)
                begin
                    res.event_kind = vtlv_pkg::EV_ENTERPRISE;
                    cnt_next       = '0;
                    phase_next     = vtlv_pkg::PH_HEADER;
                    res.status     = vtlv_pkg::ST_OK;
                end
                else
                begin
                    res.event_kind = vtlv_pkg::EV_HDR_BYTE;
                    cnt_next       = cnt_reg + 1'b1;
                    res.status     = vtlv_pkg::ST_SHORT;
                end
            end
        endcase

        res.enterprise_number = ent_next;
        res.sub_code          = code_next;
        res.sub_length        = length_next;
        if (!final_byte)
            res.status = vtlv_pkg::ST_OK;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= vtlv_pkg::PH_ENTERPRISE;
            cnt_reg       <= '0;
            ent_reg       <= '0;
            code_reg      <= '0;
            length_reg    <= '0;
            remaining_reg <= '0;
            offset_reg    <= '0;
        end
        else if (accept)
        begin
            if (final_byte)
            begin
                // end of option: back to a clean start
                phase_reg     <= vtlv_pkg::PH_ENTERPRISE;
                cnt_reg       <= '0;
                ent_reg       <= '0;
                code_reg      <= '0;
                length_reg    <= '0;
                remaining_reg <= '0;
                offset_reg    <= '0;
            end
            else
            begin
                phase_reg     <= phase_next;
                cnt_reg       <= cnt_next;
                ent_reg       <= ent_next;
                code_reg      <= code_next;
                length_reg    <= length_next;
                remaining_reg <= remaining_next;
                offset_reg    <= offset_next;
            end
        end
    end

    a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && final_byte) |=> (phase_reg == vtlv_pkg::PH_ENTERPRISE
                                    && cnt_reg == '0 && ent_reg == 32'd0))
        else $error("state not cleared after final byte");

    a_data_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == vtlv_pkg::PH_DATA) |-> (remaining_reg != 16'd0))
        else $error("data phase with nothing remaining");

    a_offset_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == vtlv_pkg::PH_DATA) |-> (offset_reg + remaining_reg == length_reg))
        else $error("data offset and remaining count out of step");

endmodule

// ===== design/vendor_option_tlv_parser_top.sv =====
// Top level: vendor option TLV parser with request and result channels.
//
// Usage:
//   payload  - request channel, one option payload byte per request, with
//              final_byte set on the last byte of the option.
//   result   - exactly one result per request: event kind, enterprise number,
//              current sub-option code/length, data byte and its offset,
//              sub-option completion, and on the final byte the status
//              (ok, too short, truncated, trailing header bytes).
// Latency: a result is valid on the cycle after its request is taken.
// Throughput: one byte per cycle unless stalled; the parse state update for
//   a byte is a small combinational step, and the result register is the only stage.
// Stall: a result held in the output register waits for result.ready;
//   payload.ready is high whenever that register is empty or being drained
//   in the same cycle, so back-to-back bytes flow with no bubble.
// Reset: the parser starts in the enterprise phase with all fields zero and
//   no result pending. After each final byte the parser clears itself and
//   the next byte opens a new option. On an error status the consumer must
//   drop the option's delivered sub-options; the parser does not enforce it.
module vendor_option_tlv_parser_top (
    input logic       clk,
    input logic       rst_n,
    vtlv_in_if.sink   payload,
    vtlv_out_if.source result
);

    vtlv_pkg::vtlv_result_t res;
    vtlv_pkg::vtlv_result_t res_reg;
    logic                   valid_reg;
    logic                   accept;

    // Take a new request when the output register is free or drains now.
    assign payload.ready = !valid_reg || result.ready;
    assign accept        = payload.valid && payload.ready;

    vtlv_parse_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .payload_byte (payload.payload_byte),
        .final_byte   (payload.final_byte),
        .res          (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (accept)
            valid_reg <= 1'b1;
        else if (result.ready)
            valid_reg <= 1'b0;
    end

    // Result payload needs no reset; it is qualified by valid_reg.
    always_ff @(posedge clk)
    begin
        if (accept)
            res_reg <= res;
    end

    assign result.valid             = valid_reg;
    assign result.event_kind        = res_reg.event_kind;
    assign result.enterprise_number = res_reg.enterprise_number;
    assign result.sub_code          = res_reg.sub_code;
    assign result.sub_length        = res_reg.sub_length;
    assign result.data_value        = res_reg.data_value;
    assign result.data_offset       = res_reg.data_offset;
    assign result.sub_complete      = res_reg.sub_complete;
    assign result.done_res          = res_reg.done_res;
    assign result.status            = res_reg.status;

    a_complete_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && res_reg.sub_complete) |->
            (res_reg.event_kind == vtlv_pkg::EV_SUB_HEADER
             || res_reg.event_kind == vtlv_pkg::EV_DATA))
        else $error("sub-option completion on a non sub-option event");

endmodule
